// ----- design/xpsc_pkg.sv -----
// Shared types, constants and helpers for the three-device XOR parity stripe codec.
package xpsc_pkg;

   localparam int unsigned BLOCK_SIZE = 1024;

   localparam int BYTE_W = 8;
   localparam int DEV_W  = 2;
   localparam int LEN_W  = 11;
   localparam int IDX_W  = 11;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   // byte_index saturates at the block size, never past its own range
   localparam int unsigned INDEX_CAP = (BLOCK_SIZE < ((1 << IDX_W) - 1)) ?
                                       BLOCK_SIZE : ((1 << IDX_W) - 1);
   localparam logic [IDX_W-1:0] INDEX_LIMIT = IDX_W'(INDEX_CAP);

   localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

   localparam logic [DEV_W-1:0] DEV_LAST       = 2'd2;
   localparam logic [DEV_W-1:0] DEV_NONE       = 2'd3;
   localparam logic [DEV_W-1:0] LOST_DEV_RESET = 2'd2;
   localparam logic [DEV_W-1:0] PARITY_RESET   = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      CMD_SPLIT = 1'b0,
      CMD_MERGE = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      REG_LOST_DEV      = 1'b0,
      REG_MISSING_BYTES = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ROUTE_SPLIT,
      ROUTE_PASS,
      ROUTE_FIX_SECOND,
      ROUTE_FIX_FIRST,
      ROUTE_NONE
   } route_type;

   typedef struct packed {
      route_type            route;
      logic [BYTE_W-1:0]    byte_first;
      logic [BYTE_W-1:0]    byte_second;
      logic [BYTE_W-1:0]    byte_par;
      logic                 has_first;
      logic                 has_second;
      logic                 has_par;
      logic                 below_limit;
      logic [DEV_W-1:0]     dev_par;
   } work_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    out_first;
      logic                 out_first_valid;
      logic [BYTE_W-1:0]    out_second;
      logic                 out_second_valid;
      logic [BYTE_W-1:0]    out_par;
      logic                 out_par_valid;
      logic [DEV_W-1:0]     dev_first;
      logic [DEV_W-1:0]     dev_second;
      logic [DEV_W-1:0]     dev_par;
   } result_type;

   // (d + 1) % 3 for d in 0..2
   function automatic logic [DEV_W-1:0] next_dev(input logic [DEV_W-1:0] d);
      logic [DEV_W-1:0] r;
      r = (d >= DEV_LAST) ? '0 : d + 2'd1;
      return r;
   endfunction

   // (d + 2) % 3 for d in 0..2
   function automatic logic [DEV_W-1:0] prev_dev(input logic [DEV_W-1:0] d);
      logic [DEV_W-1:0] r;
      r = (d == '0) ? DEV_LAST : d - 2'd1;
      return r;
   endfunction

endpackage

// ----- design/xpsc_front.sv -----
// Front end: stripe position tracking and routing classification of each accepted item.
module xpsc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_cmd,
   input  logic [xpsc_pkg::BYTE_W-1:0]   req_byte_first,
   input  logic [xpsc_pkg::BYTE_W-1:0]   req_byte_second,
   input  logic [xpsc_pkg::BYTE_W-1:0]   req_byte_par,
   input  logic                          req_has_first,
   input  logic                          req_has_second,
   input  logic                          req_has_par,
   input  logic [xpsc_pkg::LEN_W-1:0]    req_first_len,
   input  logic                          req_final_stripe,
   input  logic                          req_stripe_end,
   input  logic [xpsc_pkg::DEV_W-1:0]    lost_dev,
   input  logic [xpsc_pkg::LEN_W-1:0]    missing_bytes,
   output xpsc_pkg::work_type            work
);
   import xpsc_pkg::*;

   logic [DEV_W-1:0] par_loc_ff, par_loc_in;
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [LEN_W:0]   len_diff;
   logic [LEN_W-1:0] limit;
   route_type        route;

   always_comb begin
      len_diff = {1'b0, req_first_len} - {1'b0, missing_bytes};
      if (req_final_stripe) begin
         limit = len_diff[LEN_W] ? '0 : len_diff[LEN_W-1:0];
      end else begin
         limit = req_first_len;
      end
   end

   always_comb begin
      if (cmd_type'(req_cmd) == CMD_SPLIT) begin
         route = ROUTE_SPLIT;
      end else if (lost_dev == DEV_NONE) begin
         route = ROUTE_NONE;
      end else if (lost_dev == par_loc_ff) begin
         route = ROUTE_PASS;
      end else if (next_dev(lost_dev) == par_loc_ff) begin
         route = ROUTE_FIX_SECOND;
      end else begin
         route = ROUTE_FIX_FIRST;
      end
   end

   always_comb begin
      work.route       = route;
      work.byte_first  = req_byte_first;
      work.byte_second = req_byte_second;
      work.byte_par    = req_byte_par;
      work.has_first   = req_has_first;
      work.has_second  = req_has_second;
      work.has_par     = req_has_par;
      work.below_limit = (byte_index_ff < limit);
      work.dev_par     = par_loc_ff;
   end

   always_comb begin
      par_loc_in    = par_loc_ff;
      byte_index_in = byte_index_ff;
      if (accept) begin
         if (req_stripe_end) begin
            byte_index_in = '0;
            par_loc_in    = next_dev(par_loc_ff);
         end else if (byte_index_ff < INDEX_LIMIT) begin
            byte_index_in = byte_index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         par_loc_ff    <= PARITY_RESET;
         byte_index_ff <= '0;
      end else begin
         par_loc_ff    <= par_loc_in;
         byte_index_ff <= byte_index_in;
      end
   end

endmodule

// ----- design/xpsc_queue.sv -----
// Short work queue between the classifying front end and the byte back end.
module xpsc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  xpsc_pkg::work_type   wr_data,
   output logic                 full,
   input  logic                 rd_en,
   output xpsc_pkg::work_type   rd_data,
   output logic                 rd_valid
);
   import xpsc_pkg::*;

   work_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_wr, do_rd;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- design/xpsc_back.sv -----
// Back end: parity and rebuild XOR per routing class, with the result output register.
module xpsc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 work_valid,
   input  xpsc_pkg::work_type   work,
   output logic                 work_take,
   input  logic                 pop,
   output logic                 empty,
   output xpsc_pkg::result_type result
);
   import xpsc_pkg::*;

   result_type res_ff, res_in;
   logic       full_ff, full_in;

   always_comb begin
      res_in                  = '0;
      res_in.dev_par          = work.dev_par;
      res_in.dev_first        = next_dev(work.dev_par);
      res_in.dev_second       = prev_dev(work.dev_par);
      case (work.route)
         ROUTE_SPLIT: begin
            if (work.has_first) begin
               res_in.out_first       = work.byte_first;
               res_in.out_first_valid = 1'b1;
               res_in.out_par_valid   = 1'b1;
               if (work.has_second) begin
                  res_in.out_second       = work.byte_second;
                  res_in.out_second_valid = 1'b1;
                  res_in.out_par          = work.byte_first ^ work.byte_second;
               end else begin
                  res_in.out_par = ~work.byte_first;
               end
            end
         end
         ROUTE_PASS: begin
            if (work.has_first) begin
               res_in.out_first       = work.byte_first;
               res_in.out_first_valid = 1'b1;
            end
            if (work.has_second) begin
               res_in.out_second       = work.byte_second;
               res_in.out_second_valid = 1'b1;
            end
         end
         ROUTE_FIX_SECOND: begin
            if (work.has_first) begin
               res_in.out_first       = work.byte_first;
               res_in.out_first_valid = 1'b1;
            end
            if (work.below_limit) begin
               res_in.out_second       = work.byte_first ^ work.byte_par;
               res_in.out_second_valid = 1'b1;
            end
         end
         ROUTE_FIX_FIRST: begin
            if (work.has_second) begin
               res_in.out_first        = work.byte_second ^ work.byte_par;
               res_in.out_first_valid  = 1'b1;
               res_in.out_second       = work.byte_second;
               res_in.out_second_valid = 1'b1;
            end else if (work.has_par) begin
               // short second part: parity was stored as the inverted first byte
               res_in.out_first       = work.byte_par ^ BYTE_ONES;
               res_in.out_first_valid = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign work_take = work_valid && (!full_ff || pop);

   always_comb begin
      full_in = full_ff;
      if (work_take) begin
         full_in = 1'b1;
      end else if (pop) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work_take) begin
         res_ff <= res_in;
      end
   end

   assign empty  = !full_ff;
   assign result = res_ff;

endmodule

// ----- design/three_way_xor_parity_stripe_codec.sv -----
// Three-device XOR parity stripe codec: one byte position per item, split or merge,
// with rotating parity. An item is classified as it is accepted, waits in a four-entry
// queue and is then registered by the back end; one item is accepted per cycle as
// long as results are popped, the rate being set by the classify and XOR stages.
// full rises when all four queue entries are occupied, which happens only while the
// output register is occupied as well. Configuration (failed device index at byte
// address 0, missing secondary byte count at 4) is to be written by the user only while
// no items are in flight; the block itself does not enforce this.
module three_way_xor_parity_stripe_codec (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          push,
   output logic                          full,
   input  logic                          req_cmd,
   input  logic [xpsc_pkg::BYTE_W-1:0]   req_byte_first,
   input  logic [xpsc_pkg::BYTE_W-1:0]   req_byte_second,
   input  logic [xpsc_pkg::BYTE_W-1:0]   req_byte_par,
   input  logic                          req_has_first,
   input  logic                          req_has_second,
   input  logic                          req_has_par,
   input  logic [xpsc_pkg::LEN_W-1:0]    req_first_len,
   input  logic                          req_final_stripe,
   input  logic                          req_stripe_end,
   // response channel
   output logic                          empty,
   input  logic                          pop,
   output logic [xpsc_pkg::BYTE_W-1:0]   rsp_out_first,
   output logic                          rsp_out_first_valid,
   output logic [xpsc_pkg::BYTE_W-1:0]   rsp_out_second,
   output logic                          rsp_out_second_valid,
   output logic [xpsc_pkg::BYTE_W-1:0]   rsp_out_par,
   output logic                          rsp_out_par_valid,
   output logic [xpsc_pkg::DEV_W-1:0]    rsp_dev_first,
   output logic [xpsc_pkg::DEV_W-1:0]    rsp_dev_second,
   output logic [xpsc_pkg::DEV_W-1:0]    rsp_dev_par,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [xpsc_pkg::ADDR_W-1:0]   paddr,
   input  logic [xpsc_pkg::DATA_W-1:0]   pwdata,
   output logic [xpsc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import xpsc_pkg::*;

   logic [DEV_W-1:0] lost_dev_ff, lost_dev_in;
   logic [LEN_W-1:0] missing_bytes_ff, missing_bytes_in;
   logic             csr_write;
   reg_index_type    csr_index;

   logic             accept;
   work_type         front_work;
   work_type         queue_work;
   logic             queue_valid;
   logic             queue_take;
   result_type       result;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[ADDR_W-1]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      lost_dev_in      = lost_dev_ff;
      missing_bytes_in = missing_bytes_ff;
      if (csr_write) begin
         case (csr_index)
            REG_LOST_DEV:      lost_dev_in      = pwdata[DEV_W-1:0];
            REG_MISSING_BYTES: missing_bytes_in = pwdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LOST_DEV:      prdata = {{(DATA_W-DEV_W){1'b0}}, lost_dev_ff};
         REG_MISSING_BYTES: prdata = {{(DATA_W-LEN_W){1'b0}}, missing_bytes_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lost_dev_ff      <= LOST_DEV_RESET;
         missing_bytes_ff <= '0;
      end else begin
         lost_dev_ff      <= lost_dev_in;
         missing_bytes_ff <= missing_bytes_in;
      end
   end

   assign accept = push && !full;

   xpsc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_cmd          (req_cmd),
      .req_byte_first   (req_byte_first),
      .req_byte_second  (req_byte_second),
      .req_byte_par     (req_byte_par),
      .req_has_first    (req_has_first),
      .req_has_second   (req_has_second),
      .req_has_par      (req_has_par),
      .req_first_len    (req_first_len),
      .req_final_stripe (req_final_stripe),
      .req_stripe_end   (req_stripe_end),
      .lost_dev         (lost_dev_ff),
      .missing_bytes    (missing_bytes_ff),
      .work             (front_work)
   );

   xpsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_data  (front_work),
      .full     (full),
      .rd_en    (queue_take),
      .rd_data  (queue_work),
      .rd_valid (queue_valid)
   );

   xpsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (queue_valid),
      .work       (queue_work),
      .work_take  (queue_take),
      .pop        (pop),
      .empty      (empty),
      .result     (result)
   );

   assign rsp_out_first        = result.out_first;
   assign rsp_out_first_valid  = result.out_first_valid;
   assign rsp_out_second       = result.out_second;
   assign rsp_out_second_valid = result.out_second_valid;
   assign rsp_out_par          = result.out_par;
   assign rsp_out_par_valid    = result.out_par_valid;
   assign rsp_dev_first        = result.dev_first;
   assign rsp_dev_second       = result.dev_second;
   assign rsp_dev_par          = result.dev_par;

endmodule

// ----- design/xpsc_checker.sv -----
// Port-level checker for the stripe codec and its bind to the top level.
module xpsc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          empty,
   input logic                          pop,
   input logic [xpsc_pkg::BYTE_W-1:0]   rsp_out_first,
   input logic                          rsp_out_first_valid,
   input logic [xpsc_pkg::BYTE_W-1:0]   rsp_out_second,
   input logic                          rsp_out_second_valid,
   input logic                          rsp_out_par_valid,
   input logic [xpsc_pkg::DEV_W-1:0]    rsp_dev_first,
   input logic [xpsc_pkg::DEV_W-1:0]    rsp_dev_second,
   input logic [xpsc_pkg::DEV_W-1:0]    rsp_dev_par
);
   import xpsc_pkg::*;

   // no result may be presented right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result shown right after reset");

   // the three devices of a stripe are always distinct
   a_devs_distinct: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_dev_first != rsp_dev_par) && (rsp_dev_second != rsp_dev_par) &&
                 (rsp_dev_first != rsp_dev_second))
      else $error("device numbers collide");

   // parity only comes out of a split with a first byte
   a_par_needs_first: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_out_par_valid) |-> rsp_out_first_valid)
      else $error("parity without primary byte");

   // bytes that are not valid read as zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_out_first_valid || rsp_out_first == '0) &&
                 (rsp_out_second_valid || rsp_out_second == '0))
      else $error("invalid byte not zero");

   // a waiting result holds until its transfer
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_first) && $stable(rsp_dev_par)))
      else $error("waiting result changed");

endmodule

bind three_way_xor_parity_stripe_codec xpsc_checker u_xpsc_checker (.*);
